// ===== sv/mbet_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time pixel block.
// Used by mbet_ctrl, mbet_dp and mandelbrot_escape_time_pixel; no dependencies.
package mbet_pkg;

   localparam int FRAC_BITS  = 28;
   localparam int COORD_BITS = 10;
   localparam int Z_W        = 32;
   localparam int CNT_W      = 16;
   localparam int RSTEP_W    = 31;
   localparam int GRAY_W     = 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int PRD_W  = 2 * Z_W;
   localparam int SQ_W   = PRD_W - FRAC_BITS;
   localparam int RI_W   = PRD_W - FRAC_BITS + 1;
   localparam int CMP_W  = (SQ_W + 1 > FRAC_BITS + 3) ? SQ_W + 1 : FRAC_BITS + 3;
   localparam int CPRD_W = RSTEP_W + COORD_BITS;
   localparam int SAT_W  = (SQ_W + 2 > CPRD_W + 2) ? SQ_W + 2 : CPRD_W + 2;
   localparam int NUM_W  = CNT_W + GRAY_W;
   localparam int STEP_W = $clog2(GRAY_W);

   localparam logic signed [CMP_W-1:0] FOUR_Q = CMP_W'(4) << FRAC_BITS;

   localparam int REQ_W = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RES_W = 2 * COORD_BITS + CNT_W + 1 + GRAY_W;
   localparam int RSP_W = ((RES_W + 7) / 8) * 8;

   localparam logic [CNT_W-1:0]          MAX_ITER_RST = 16'd256;
   localparam logic signed [Z_W-1:0]     RE_MIN_RST   = -32'sd402653184;
   localparam logic signed [Z_W-1:0]     IM_MIN_RST   = -32'sd268435456;
   localparam logic [RSTEP_W-1:0]        RE_STEP_RST  = 31'd2348810;
   localparam logic [RSTEP_W-1:0]        IM_STEP_RST  = 31'd1342177;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_ITER = 3'd0,
      CSR_RE_MIN   = 3'd1,
      CSR_IM_MIN   = 3'd2,
      CSR_RE_STEP  = 3'd3,
      CSR_IM_STEP  = 3'd4
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD_MUL,
      ST_COORD_ADD,
      ST_ITER_MUL,
      ST_ITER_UPD,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_HOLD
   } mbet_state_type;

   typedef struct packed {
      logic capture;
      logic coord_mul;
      logic coord_add;
      logic iter_mul;
      logic iter_upd;
      logic div_init;
      logic div_step;
      logic load_out;
   } mbet_cmd_type;

   typedef struct packed {
      logic max_zero;
      logic escape;
      logic last_iter;
      logic div_last;
   } mbet_status_type;

   typedef struct packed {
      logic [GRAY_W-1:0]     gray_level;
      logic                  inside_set;
      logic [CNT_W-1:0]      iteration_count;
      logic [COORD_BITS-1:0] out_y;
      logic [COORD_BITS-1:0] out_x;
   } mbet_result_type;

endpackage

// ===== sv/mbet_ctrl.sv =====
// Sequencing state machine for the escape-time pixel block.
// Depends on mbet_pkg; drives mbet_dp through command and status structs.
module mbet_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  mbet_pkg::mbet_status_type status,
   output mbet_pkg::mbet_cmd_type    cmd
);

   mbet_pkg::mbet_state_type state_ff, state_in;
   logic out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbet_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         mbet_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = mbet_pkg::ST_COORD_MUL;
            end
         end
         mbet_pkg::ST_COORD_MUL: begin
            cmd.coord_mul = 1'b1;
            state_in      = mbet_pkg::ST_COORD_ADD;
         end
         mbet_pkg::ST_COORD_ADD: begin
            cmd.coord_add = 1'b1;
            state_in      = status.max_zero ? mbet_pkg::ST_DIV_INIT : mbet_pkg::ST_ITER_MUL;
         end
         mbet_pkg::ST_ITER_MUL: begin
            cmd.iter_mul = 1'b1;
            state_in     = mbet_pkg::ST_ITER_UPD;
         end
         mbet_pkg::ST_ITER_UPD: begin
            if (status.escape) begin
               state_in = mbet_pkg::ST_DIV_INIT;
            end else begin
               cmd.iter_upd = 1'b1;
               state_in     = status.last_iter ? mbet_pkg::ST_DIV_INIT : mbet_pkg::ST_ITER_MUL;
            end
         end
         mbet_pkg::ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = mbet_pkg::ST_DIV_STEP;
         end
         mbet_pkg::ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = mbet_pkg::ST_HOLD;
            end
         end
         mbet_pkg::ST_HOLD: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = mbet_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbet_pkg::ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.load_out | (out_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = out_valid_ff;

endmodule

// ===== sv/mbet_dp.sv =====
// Datapath: config registers, coordinate mapping, z iteration and gray divider.
// Depends on mbet_pkg; sequenced by mbet_ctrl.
module mbet_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mbet_pkg::mbet_cmd_type               cmd,
   output mbet_pkg::mbet_status_type            status,
   input  logic [mbet_pkg::COORD_BITS-1:0]      req_x,
   input  logic [mbet_pkg::COORD_BITS-1:0]      req_y,
   input  logic                                 csr_we,
   input  logic [mbet_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mbet_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic [mbet_pkg::CNT_W-1:0]           max_iter,
   output mbet_pkg::mbet_result_type            result
);

   localparam int Z_W    = mbet_pkg::Z_W;
   localparam int SAT_W  = mbet_pkg::SAT_W;
   localparam int CNT_W  = mbet_pkg::CNT_W;
   localparam int NUM_W  = mbet_pkg::NUM_W;
   localparam int GRAY_W = mbet_pkg::GRAY_W;
   localparam int FRAC   = mbet_pkg::FRAC_BITS;
   localparam int PRD_W  = mbet_pkg::PRD_W;

   localparam logic signed [Z_W-1:0] Z_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Z_W-1:0] Z_MIN = 32'sh8000_0000;

   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SAT_W-1:0] v);
      if (v > SAT_W'(Z_MAX)) begin
         return Z_MAX;
      end else if (v < SAT_W'(Z_MIN)) begin
         return Z_MIN;
      end
      return $signed(v[Z_W-1:0]);
   endfunction

   // config registers
   logic [CNT_W-1:0]                 max_iter_ff;
   logic signed [Z_W-1:0]            re_min_ff, im_min_ff;
   logic [mbet_pkg::RSTEP_W-1:0]     re_step_ff, im_step_ff;

   // working registers
   logic [mbet_pkg::COORD_BITS-1:0]  x_ff, x_in, y_ff, y_in;
   logic [mbet_pkg::CPRD_W-1:0]      pcr_ff, pcr_in, pci_ff, pci_in;
   logic signed [Z_W-1:0]            cr_ff, cr_in, ci_ff, ci_in;
   logic signed [Z_W-1:0]            zr_ff, zr_in, zi_ff, zi_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic signed [PRD_W-1:0]          p_rr_ff, p_rr_in, p_ii_ff, p_ii_in, p_ri_ff, p_ri_in;
   logic [NUM_W-1:0]                 rem_ff, rem_in, dvs_ff, dvs_in;
   logic [GRAY_W-1:0]                quo_ff, quo_in;
   logic [mbet_pkg::STEP_W-1:0]      step_ff, step_in;
   mbet_pkg::mbet_result_type        res_ff, res_in;

   logic signed [mbet_pkg::SQ_W-1:0]  sq_r, sq_i;
   logic signed [mbet_pkg::RI_W-1:0]  sq_ri;
   logic signed [mbet_pkg::CMP_W-1:0] mag;
   logic signed [SAT_W-1:0]           cr_sum, ci_sum, zr_sum, zi_sum;
   logic [CNT_W-1:0]                  diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= mbet_pkg::MAX_ITER_RST;
         re_min_ff   <= mbet_pkg::RE_MIN_RST;
         im_min_ff   <= mbet_pkg::IM_MIN_RST;
         re_step_ff  <= mbet_pkg::RE_STEP_RST;
         im_step_ff  <= mbet_pkg::IM_STEP_RST;
      end else if (csr_we) begin
         case (csr_index)
            mbet_pkg::CSR_MAX_ITER: max_iter_ff <= csr_wdata[CNT_W-1:0];
            mbet_pkg::CSR_RE_MIN:   re_min_ff   <= $signed(csr_wdata[Z_W-1:0]);
            mbet_pkg::CSR_IM_MIN:   im_min_ff   <= $signed(csr_wdata[Z_W-1:0]);
            mbet_pkg::CSR_RE_STEP:  re_step_ff  <= csr_wdata[mbet_pkg::RSTEP_W-1:0];
            mbet_pkg::CSR_IM_STEP:  im_step_ff  <= csr_wdata[mbet_pkg::RSTEP_W-1:0];
            default: ;
         endcase
      end
   end

   // floor shifts are plain part-selects of the products
   assign sq_r   = $signed(p_rr_ff[PRD_W-1:FRAC]);
   assign sq_i   = $signed(p_ii_ff[PRD_W-1:FRAC]);
   assign sq_ri  = $signed(p_ri_ff[PRD_W-1:FRAC-1]);
   assign mag    = mbet_pkg::CMP_W'(sq_r) + mbet_pkg::CMP_W'(sq_i);
   assign zr_sum = SAT_W'(sq_r) - SAT_W'(sq_i) + SAT_W'(cr_ff);
   assign zi_sum = SAT_W'(sq_ri) + SAT_W'(ci_ff);
   assign cr_sum = SAT_W'(re_min_ff) + SAT_W'(pcr_ff);
   assign ci_sum = SAT_W'(im_min_ff) + SAT_W'(pci_ff);
   assign diff   = max_iter_ff - count_ff;

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      pcr_in   = pcr_ff;
      pci_in   = pci_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      count_in = count_ff;
      p_rr_in  = p_rr_ff;
      p_ii_in  = p_ii_ff;
      p_ri_in  = p_ri_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      res_in   = res_ff;
      if (cmd.capture) begin
         x_in = req_x;
         y_in = req_y;
      end
      if (cmd.coord_mul) begin
         pcr_in = mbet_pkg::CPRD_W'(re_step_ff) * mbet_pkg::CPRD_W'(x_ff);
         pci_in = mbet_pkg::CPRD_W'(im_step_ff) * mbet_pkg::CPRD_W'(y_ff);
      end
      if (cmd.coord_add) begin
         cr_in    = sat_z(cr_sum);
         ci_in    = sat_z(ci_sum);
         zr_in    = '0;
         zi_in    = '0;
         count_in = '0;
      end
      if (cmd.iter_mul) begin
         p_rr_in = PRD_W'(zr_ff) * PRD_W'(zr_ff);
         p_ii_in = PRD_W'(zi_ff) * PRD_W'(zi_ff);
         p_ri_in = PRD_W'(zr_ff) * PRD_W'(zi_ff);
      end
      if (cmd.iter_upd) begin
         zr_in    = sat_z(zr_sum);
         zi_in    = sat_z(zi_sum);
         count_in = count_ff + 1'b1;
      end
      // numerator 255*(max-count) as (d << 8) - d
      if (cmd.div_init) begin
         rem_in  = (NUM_W'(diff) << GRAY_W) - NUM_W'(diff);
         dvs_in  = NUM_W'(max_iter_ff) << (GRAY_W - 1);
         quo_in  = '0;
         step_in = mbet_pkg::STEP_W'(GRAY_W - 1);
      end
      if (cmd.div_step) begin
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
            quo_in = {quo_ff[GRAY_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[GRAY_W-2:0], 1'b0};
         end
         dvs_in  = dvs_ff >> 1;
         step_in = step_ff - 1'b1;
      end
      if (cmd.load_out) begin
         res_in.out_x           = x_ff;
         res_in.out_y           = y_ff;
         res_in.iteration_count = count_ff;
         res_in.inside_set      = (count_ff == max_iter_ff);
         // zero limit divides by zero; inside points are dark
         res_in.gray_level      = (count_ff == max_iter_ff) ? '0 : quo_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      pcr_ff   <= pcr_in;
      pci_ff   <= pci_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      count_ff <= count_in;
      p_rr_ff  <= p_rr_in;
      p_ii_ff  <= p_ii_in;
      p_ri_ff  <= p_ri_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      res_ff   <= res_in;
   end

   assign status.max_zero  = (max_iter_ff == '0);
   assign status.escape    = (mag >= mbet_pkg::FOUR_Q);
   assign status.last_iter = (CNT_W'(count_ff + 1'b1) == max_iter_ff);
   assign status.div_last  = (step_ff == '0);
   assign max_iter         = max_iter_ff;
   assign result           = res_ff;

endmodule

// ===== sv/mandelbrot_escape_time_pixel.sv =====
// Mandelbrot escape-time pixel evaluator, top level; depends on mbet_pkg, mbet_ctrl, mbet_dp.
// The block works on one pixel at a time: two coordinate steps, then a multiply step
// and an update step for each iteration, then the gray divider (an init step and
// its divide steps) before the result is loaded into the output register.
// The next pixel is taken while the result waits in the output register.
// Reset (synchronous, active high) idles the block and restores register defaults.
module mandelbrot_escape_time_pixel (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mbet_pkg::REQ_W-1:0]         req_tdata,   // pixel_x, pixel_y
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mbet_pkg::RSP_W-1:0]         rsp_tdata,   // out_x, out_y, iteration_count,
                                                            // inside_set, gray_level
   input  logic                               csr_we,
   input  logic [mbet_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mbet_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CB = mbet_pkg::COORD_BITS;

   mbet_pkg::mbet_cmd_type    cmd;
   mbet_pkg::mbet_status_type status;
   mbet_pkg::mbet_result_type result;
   logic [mbet_pkg::CNT_W-1:0] max_iter;

   mbet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mbet_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_x     (req_tdata[CB-1:0]),
      .req_y     (req_tdata[2*CB-1:CB]),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .max_iter  (max_iter),
      .result    (result)
   );

   assign rsp_tdata = mbet_pkg::RSP_W'(result);

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while a pixel is in flight");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_tvalid)
      else $error("loaded result not presented");

   a_inside_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.inside_set |-> result.gray_level == '0
         && result.iteration_count == max_iter)
      else $error("inside point with nonzero gray or short count");
`endif

endmodule

// ===== bench/tb_mandelbrot_escape_time_pixel.sv =====
`timescale 1ns / 100ps
// Self-checking bench for mandelbrot_escape_time_pixel: directed table, then random
// views of the complex plane, each result checked against a table value or an escape-time predictor.
// Depends on mbet_pkg and the block's RTL.
module tb_mandelbrot_escape_time_pixel;

   localparam int CSR_IDX_W  = mbet_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = mbet_pkg::CSR_DATA_W;
   localparam int COORD_BITS = mbet_pkg::COORD_BITS;
   localparam int CNT_W      = mbet_pkg::CNT_W;
   localparam int GRAY_W     = mbet_pkg::GRAY_W;
   localparam int Z_W        = mbet_pkg::Z_W;
   localparam int RSTEP_W    = mbet_pkg::RSTEP_W;
   localparam int FRAC_BITS  = mbet_pkg::FRAC_BITS;
   localparam int REQ_W      = mbet_pkg::REQ_W;
   localparam int RSP_W      = mbet_pkg::RSP_W;
   localparam int RES_W      = mbet_pkg::RES_W;

   localparam int unsigned LIMIT_CYCLES = 5_000_000;
   localparam int unsigned HOLD_CYCLES  = 3000;
   localparam int unsigned DRAIN_CYCLES = 700;
   localparam int unsigned RANDOM_ITEMS = 1150;
   localparam int          DIR_ROWS     = 39;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_5 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_7 = 3'd7;

   typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_type;
   typedef enum logic [2:0] {VIEW_NEAR, VIEW_DEEP, VIEW_WILD, VIEW_TINY, VIEW_EDGE} view_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_IDX_W-1:0]      idx;
      logic [CSR_DATA_W-1:0]     value;
      logic [COORD_BITS-1:0]     x;
      logic [COORD_BITS-1:0]     y;
      logic                      known;
      mbet_pkg::mbet_result_type want;
   } dir_row_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_W-1:0]        req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_W-1:0]        rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   // shadow of the block's registers
   logic [CNT_W-1:0]        iter_limit = mbet_pkg::MAX_ITER_RST;
   logic signed [Z_W-1:0]   re_origin  = mbet_pkg::RE_MIN_RST;
   logic signed [Z_W-1:0]   im_origin  = mbet_pkg::IM_MIN_RST;
   logic [RSTEP_W-1:0]      re_pitch   = mbet_pkg::RE_STEP_RST;
   logic [RSTEP_W-1:0]      im_pitch   = mbet_pkg::IM_STEP_RST;

   mbet_pkg::mbet_result_type pending_pixels [$];
   dir_row_type               dir_rows [DIR_ROWS];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned items_sent    = 0;
   int unsigned results_seen  = 0;
   int unsigned mismatches    = 0;
   int unsigned settings_used = 0;
   int unsigned cycle_count   = 0;
   logic        hold_req      = 1'b0;
   logic        hold_taken    = 1'b0;
   int unsigned hold_left     = 0;

   mandelbrot_escape_time_pixel i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_q(input longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
      if (v < -longint'(64'sh8000_0000)) return -longint'(64'sh8000_0000);
      return v;
   endfunction

   function automatic mbet_pkg::mbet_result_type escape_time_of(
      input logic [COORD_BITS-1:0] x,
      input logic [COORD_BITS-1:0] y);
      longint                    cr, ci, zr, zi, r2, i2, ri, four;
      int unsigned               count, lim;
      mbet_pkg::mbet_result_type r;
      lim   = iter_limit;
      four  = longint'(4) <<< FRAC_BITS;
      cr    = clamp_q(longint'(re_origin) + longint'(re_pitch) * longint'(x));
      ci    = clamp_q(longint'(im_origin) + longint'(im_pitch) * longint'(y));
      zr    = 0;
      zi    = 0;
      count = 0;
      while (count < lim) begin
         r2 = (zr * zr) >>> FRAC_BITS;
         i2 = (zi * zi) >>> FRAC_BITS;
         if (r2 + i2 >= four) break;
         ri = (zr * zi) >>> (FRAC_BITS - 1);
         zr = clamp_q(r2 - i2 + cr);
         zi = clamp_q(ri + ci);
         count++;
      end
      r.out_x           = x;
      r.out_y           = y;
      r.iteration_count = CNT_W'(count);
      r.inside_set      = (count == lim);
      r.gray_level      = r.inside_set ? '0 : GRAY_W'((32'd255 * (lim - count)) / lim);
      return r;
   endfunction

   function automatic dir_row_type row_write(input logic [CSR_IDX_W-1:0] idx,
                                             input logic [CSR_DATA_W-1:0] value);
      dir_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.idx   = idx;
      row.value = value;
      return row;
   endfunction

   function automatic dir_row_type row_pixel(input logic [COORD_BITS-1:0] x,
                                             input logic [COORD_BITS-1:0] y);
      dir_row_type row;
      row      = '0;
      row.kind = ROW_PIXEL;
      row.x    = x;
      row.y    = y;
      return row;
   endfunction

   function automatic dir_row_type row_known(input logic [COORD_BITS-1:0] x,
                                             input logic [COORD_BITS-1:0] y,
                                             input logic [CNT_W-1:0] count,
                                             input logic in_set,
                                             input logic [GRAY_W-1:0] gray);
      dir_row_type row;
      row       = row_pixel(x, y);
      row.known = 1'b1;
      row.want  = '{gray_level: gray, inside_set: in_set, iteration_count: count,
                    out_y: y, out_x: x};
      return row;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         mbet_pkg::CSR_MAX_ITER: iter_limit = value[CNT_W-1:0];
         mbet_pkg::CSR_RE_MIN:   re_origin  = value;
         mbet_pkg::CSR_IM_MIN:   im_origin  = value;
         mbet_pkg::CSR_RE_STEP:  re_pitch   = value[RSTEP_W-1:0];
         mbet_pkg::CSR_IM_STEP:  im_pitch   = value[RSTEP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
                             input logic known, input mbet_pkg::mbet_result_type want);
      csr_we <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({y, x});
      do @(posedge clock); while (!req_tready);
      pending_pixels.push_back(known ? want : escape_time_of(x, y));
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // result side: check, then pick next ready (long hold once on request)
   always @(posedge clock) begin : rsp_side
      mbet_pkg::mbet_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = mbet_pkg::mbet_result_type'(rsp_tdata[RES_W-1:0]);
         results_seen++;
         if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result x=%0d y=%0d with no item pending", got.out_x, got.out_y);
         end else begin
            want = pending_pixels.pop_front();
            if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
                got.iteration_count !== want.iteration_count ||
                got.inside_set !== want.inside_set || got.gray_level !== want.gray_level) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: exp %0d,%0d n=%0d in=%0d g=%0d, got %0d,%0d n=%0d in=%0d g=%0d",
                           want.out_x, want.out_y, want.iteration_count, want.inside_set,
                           want.gray_level, got.out_x, got.out_y, got.iteration_count,
                           got.inside_set, got.gray_level);
            end
         end
      end
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_pixels.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      view_kind_type      kind;
      int unsigned        pick, n_items, i;
      logic [CNT_W-1:0]   max16;
      logic [Z_W-1:0]     rmin, imin;
      logic [RSTEP_W-1:0] rstep, istep;
      logic               after_pixel;

      dir_rows = '{
         row_known(0, 0, 2, 1'b0, 253),
         row_pixel(1023, 1023),
         row_pixel(10'h2AA, 10'h155),
         row_pixel(10'h155, 10'h2AA),
         row_write(mbet_pkg::CSR_MAX_ITER, 32'd0),
         row_known(1023, 0, 0, 1'b1, 0),
         row_known(0, 1023, 0, 1'b1, 0),
         row_write(mbet_pkg::CSR_MAX_ITER, 32'hFFFF_0001),
         row_known(0, 0, 1, 1'b1, 0),
         row_known(1023, 1023, 1, 1'b1, 0),
         row_write(mbet_pkg::CSR_MAX_ITER, 32'd16),
         row_write(mbet_pkg::CSR_RE_MIN, 32'h8000_0000),
         row_write(mbet_pkg::CSR_IM_MIN, 32'h7FFF_FFFF),
         row_write(mbet_pkg::CSR_RE_STEP, 32'hFFFF_FFFF),
         row_write(mbet_pkg::CSR_IM_STEP, 32'd0),
         row_pixel(0, 0),
         row_pixel(1023, 1023),
         row_pixel(1, 1),
         row_write(CSR_UNMAPPED_5, 32'hFFFF_FFFF),
         row_write(CSR_UNMAPPED_6, 32'hFFFF_FFFF),
         row_write(CSR_UNMAPPED_7, 32'hFFFF_FFFF),
         row_pixel(0, 0),
         row_write(mbet_pkg::CSR_RE_MIN, 32'd0),
         row_write(mbet_pkg::CSR_IM_MIN, 32'd0),
         row_write(mbet_pkg::CSR_RE_STEP, 32'd0),
         row_write(mbet_pkg::CSR_IM_STEP, 32'd0),
         row_write(mbet_pkg::CSR_MAX_ITER, 32'h0000_FFFF),
         row_known(1023, 1023, 16'hFFFF, 1'b1, 0),
         row_write(mbet_pkg::CSR_RE_MIN, 32'h2000_0000),
         row_known(0, 0, 1, 1'b0, 254),
         row_write(mbet_pkg::CSR_RE_MIN, 32'hE000_0000),
         row_pixel(0, 0),
         row_write(mbet_pkg::CSR_MAX_ITER, 32'd256),
         row_write(mbet_pkg::CSR_RE_STEP, 32'h0010_0000),
         row_write(mbet_pkg::CSR_IM_STEP, 32'h0008_0000),
         row_write(mbet_pkg::CSR_IM_MIN, 32'hF000_0000),
         row_pixel(400, 512),
         row_pixel(600, 300),
         row_pixel(511, 200)
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 24;
      recv_idle_pct = 49;
      after_pixel   = 1'b0;
      foreach (dir_rows[r]) begin
         if (dir_rows[r].kind == ROW_WRITE) begin
            if (after_pixel) begin
               wait_idle();
               settings_used++;
            end
            write_reg(dir_rows[r].idx, dir_rows[r].value);
            after_pixel = 1'b0;
         end else begin
            send_pixel(dir_rows[r].x, dir_rows[r].y, dir_rows[r].known, dir_rows[r].want);
            after_pixel = 1'b1;
         end
      end

      while (items_sent < RANDOM_ITEMS + 18) begin
         wait_idle();
         settings_used++;
         if (items_sent > 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (items_sent > RANDOM_ITEMS / 3) begin
            send_idle_pct = 49;
            recv_idle_pct = 24;
         end

         pick  = $urandom_range(9);
         kind  = (pick < 5) ? VIEW_NEAR : view_kind_type'(pick - 5);
         max16 = CNT_W'($urandom_range(1, 48));
         n_items = $urandom_range(30, 80);
         // window origin near the set: re min in [-2.25, -0.75], im min in [-1.25, -0.75]
         rmin  = -32'sd603979776 + 32'($urandom_range(0, 402653184));
         imin  = -32'sd335544320 + 32'($urandom_range(0, 134217728));
         rstep = RSTEP_W'($urandom_range(150000, 800000));
         istep = RSTEP_W'($urandom_range(100000, 700000));
         case (kind)
            VIEW_DEEP: begin
               max16   = CNT_W'($urandom_range(100, 300));
               n_items = $urandom_range(10, 20);
            end
            VIEW_WILD: begin
               max16 = CNT_W'($urandom_range(0, 40));
               rmin  = $urandom;
               imin  = $urandom;
               rstep = RSTEP_W'($urandom);
               istep = RSTEP_W'($urandom);
            end
            VIEW_TINY: max16 = CNT_W'($urandom_range(0, 1));
            VIEW_EDGE: begin
               max16 = CNT_W'($urandom_range(1, 20));
               rmin  = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
               imin  = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
               rstep = $urandom_range(1) ? '1 : '0;
               istep = $urandom_range(1) ? '1 : '0;
            end
            default: ;
         endcase

         write_reg(mbet_pkg::CSR_MAX_ITER, {16'($urandom), max16});
         write_reg(mbet_pkg::CSR_RE_MIN, rmin);
         write_reg(mbet_pkg::CSR_IM_MIN, imin);
         write_reg(mbet_pkg::CSR_RE_STEP, {1'($urandom), rstep});
         write_reg(mbet_pkg::CSR_IM_STEP, {1'($urandom), istep});
         if ($urandom_range(3) == 0)
            write_reg(CSR_UNMAPPED_5 + CSR_IDX_W'($urandom_range(2)), $urandom);

         // one long result-side stall while items keep coming
         if (settings_used == 12) begin
            max16 = CNT_W'($urandom_range(1, 16));
            write_reg(mbet_pkg::CSR_MAX_ITER, 32'(max16));
            hold_req <= 1'b1;
         end

         for (i = 0; i < n_items; i++)
            send_pixel(COORD_BITS'($urandom), COORD_BITS'($urandom), 1'b0, '0);
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d pixels under %0d register settings, %0d results checked",
               items_sent, settings_used, results_seen);
      $display("summary: %0d mismatches, %0d cycles", mismatches, cycle_count);
      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
